[design/rbs_pkg.sv]
// Package: shared types, constants and a compare helper for the ray/box slab test.
`timescale 1ns / 1ps
package rbs_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_idx_t;

  localparam coord_t ONE_FX     = coord_t'(1 << FRAC_W);
  localparam coord_t NEG_ONE_FX = -coord_t'(1 << FRAC_W);
  localparam coord_t COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_distance;
  } out_t;

  // Distance class; encoding order matches numeric order
  typedef enum logic [1:0] {
    CLS_NEG_INF = 2'd0,
    CLS_FINITE  = 2'd1,
    CLS_POS_INF = 2'd2
  } dcls_t;

  typedef struct packed {
    dcls_t  cls;
    coord_t v;
  } dist_t;

  // a < b over extended distances
  function automatic logic dist_lt(input dist_t a, input dist_t b);
    logic res;
    if (a.cls != b.cls) begin
      res = (a.cls < b.cls);
    end else begin
      res = (a.cls == CLS_FINITE) && (a.v < b.v);
    end
    return res;
  endfunction

endpackage

[design/ray_box_slab_intersect_core.sv]
// 14 register stages with the default STEPS_PER_STAGE = 4: setup, divider entry,
//   ceil(33 / STEPS_PER_STAGE) restoring-division stages, divider output, reduce and output.
// Throughput: one ray per cycle when not stalled; six dividers share the pipeline depth.
// Each stage holds its item until the next stage frees, so stalls compress bubbles.
// Reset (rst, synchronous): clears all stage valid bits; box bounds return to -1.0 / +1.0.
`timescale 1ns / 1ps
module ray_box_slab_intersect_core
  import rbs_pkg::*;
  #(parameter int STEPS_PER_STAGE = 4)
  (
    input  logic                 clk,
    input  logic                 rst,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [COORD_W-1:0]   cfg_data
  );

  localparam int QB   = COORD_W + 1;
  localparam int NSTG = (QB + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DS   = NSTG + 2;
  localparam int L    = DS + 3;

  // box registers
  coord_t box_lo [3];
  coord_t box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= NEG_ONE_FX;
        box_hi[a] <= ONE_FX;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BOX_MIN_X: box_lo[0] <= cfg_data;
        CFG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        CFG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        CFG_BOX_MAX_X: box_hi[0] <= cfg_data;
        CFG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        CFG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [L-1:0] v;
  logic [L-1:0] en;
  logic [L-1:0] vin;

  always_comb begin
    en[L-1] = !v[L-1] || out_ready;
    for (int j = L - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign vin = {v[L-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < L; j++) begin
        if (en[j]) begin
          v[j] <= vin[j];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[L-1];

  // setup stage: operand magnitudes, signs, zero-direction classes
  coord_t org [3];
  coord_t dir [3];
  assign org[0] = in_data.origin_x;
  assign org[1] = in_data.origin_y;
  assign org[2] = in_data.origin_z;
  assign dir[0] = in_data.dir_x;
  assign dir[1] = in_data.dir_y;
  assign dir[2] = in_data.dir_z;

  logic [COORD_W:0]   n_en_r  [3];
  logic [COORD_W:0]   n_ex_r  [3];
  logic [COORD_W-1:0] d_mag_r [3];
  logic               neg_en_r [3];
  logic               neg_ex_r [3];
  logic [11:0]        cls_in;
  logic [11:0]        cls_out;
  dcls_t              cls_en_r [3];
  dcls_t              cls_ex_r [3];
  coord_t             dv_en [3];
  coord_t             dv_ex [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    coord_t             b_en;
    coord_t             b_ex;
    logic [COORD_W:0]   df_en;
    logic [COORD_W:0]   df_ex;
    logic               dneg;
    logic               dzero;
    dcls_t              c_en;
    dcls_t              c_ex;

    always_comb begin
      dneg  = dir[a][COORD_W-1];
      dzero = (dir[a] == '0);
      b_en  = dneg ? box_hi[a] : box_lo[a];
      b_ex  = dneg ? box_lo[a] : box_hi[a];
      df_en = {b_en[COORD_W-1], b_en} - {org[a][COORD_W-1], org[a]};
      df_ex = {b_ex[COORD_W-1], b_ex} - {org[a][COORD_W-1], org[a]};
      if (!dzero) begin
        c_en = CLS_FINITE;
        c_ex = CLS_FINITE;
      end else if (org[a] < box_lo[a]) begin
        c_en = CLS_POS_INF;
        c_ex = CLS_POS_INF;
      end else if (org[a] > box_hi[a]) begin
        c_en = CLS_NEG_INF;
        c_ex = CLS_NEG_INF;
      end else begin
        c_en = CLS_NEG_INF;
        c_ex = CLS_POS_INF;
      end
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        n_en_r[a]   <= df_en[COORD_W] ? -df_en : df_en;
        n_ex_r[a]   <= df_ex[COORD_W] ? -df_ex : df_ex;
        d_mag_r[a]  <= dneg ? -dir[a] : dir[a];
        neg_en_r[a] <= df_en[COORD_W] ^ dneg;
        neg_ex_r[a] <= df_ex[COORD_W] ^ dneg;
        cls_en_r[a] <= c_en;
        cls_ex_r[a] <= c_ex;
      end
    end

    rbs_div #(.STEPS(STEPS_PER_STAGE)) u_div_en (
      .clk    (clk),
      .en     (en[DS:1]),
      .n      (n_en_r[a]),
      .d      (d_mag_r[a]),
      .neg    (neg_en_r[a]),
      .slab_d (dv_en[a])
    );

    rbs_div #(.STEPS(STEPS_PER_STAGE)) u_div_ex (
      .clk    (clk),
      .en     (en[DS:1]),
      .n      (n_ex_r[a]),
      .d      (d_mag_r[a]),
      .neg    (neg_ex_r[a]),
      .slab_d (dv_ex[a])
    );

    assign cls_in[4*a +: 4] = {cls_en_r[a], cls_ex_r[a]};
  end

  // classes ride alongside the dividers
  rbs_delay #(.WIDTH(12), .DEPTH(DS)) u_cls_dly (
    .clk (clk),
    .en  (en[DS:1]),
    .d   (cls_in),
    .q   (cls_out)
  );

  // reduce: largest entry, smallest exit
  dist_t t0, t1;
  dist_t t0_next, t1_next;

  always_comb begin
    dist_t e;
    dist_t x;
    t0_next = '{cls: CLS_NEG_INF, v: '0};
    t1_next = '{cls: CLS_POS_INF, v: '0};
    for (int a = 0; a < 3; a++) begin
      e.cls = dcls_t'(cls_out[4*a+2 +: 2]);
      e.v   = dv_en[a];
      x.cls = dcls_t'(cls_out[4*a +: 2]);
      x.v   = dv_ex[a];
      if (dist_lt(t0_next, e)) begin
        t0_next = e;
      end
      if (dist_lt(x, t1_next)) begin
        t1_next = x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DS+1]) begin
      t0 <= t0_next;
      t1 <= t1_next;
    end
  end

  // hit decision and distance select
  dist_t zero_d;
  dist_t tsel;
  out_t  res_next;

  assign zero_d = '{cls: CLS_FINITE, v: '0};

  always_comb begin
    tsel = dist_lt(t0, zero_d) ? t1 : t0;
    res_next.hit = dist_lt(t0, t1) && dist_lt(zero_d, t1);
    case (tsel.cls)
      CLS_POS_INF: res_next.hit_distance = COORD_MAX;
      CLS_NEG_INF: res_next.hit_distance = COORD_MIN;
      default:     res_next.hit_distance = tsel.v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      out_data <= res_next;
    end
  end

endmodule

[design/rbs_delay.sv]
// Sideband delay line that follows the pipeline stage enables.
`timescale 1ns / 1ps
module rbs_delay
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 4)
  (
    input  logic             clk,
    input  logic [DEPTH-1:0] en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
  );

  logic [WIDTH-1:0] tap [DEPTH];

  // one register per stage, loaded when that stage advances
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (en[i]) begin
        tap[i] <= (i == 0) ? d : tap[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

[design/rbs_div.sv]
// Pipelined restoring divider: saturated fixed-point (n << FRAC) / d with sign.
`timescale 1ns / 1ps
module rbs_div
  import rbs_pkg::*;
  #(parameter int STEPS = 4,
    localparam int QB   = COORD_W + 1,
    localparam int NSTG = (QB + STEPS - 1) / STEPS,
    localparam int DS   = NSTG + 2)
  (
    input  logic             clk,
    input  logic [DS-1:0]    en,
    input  logic [COORD_W:0] n,
    input  logic [COORD_W-1:0] d,
    input  logic             neg,
    output coord_t           slab_d
  );

  typedef struct packed {
    logic               ovf;
    logic               neg;
    logic [COORD_W-1:0] dv;
    logic [COORD_W-1:0] rem;
    logic [QB-1:0]      feed;
    logic [QB-1:0]      quo;
  } dstate_t;

  dstate_t stg [NSTG+1];
  dstate_t pre;

  // setup: overflow check on the high dividend part, seed remainder
  always_comb begin
    pre.ovf  = {{(COORD_W-FRAC_W){1'b0}}, n[COORD_W:COORD_W+1-FRAC_W]} >= d;
    pre.neg  = neg;
    pre.dv   = d;
    pre.rem  = {{(COORD_W-FRAC_W){1'b0}}, n[COORD_W:COORD_W+1-FRAC_W]};
    pre.feed = {n[COORD_W-FRAC_W:0], {FRAC_W{1'b0}}};
    pre.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg[0] <= pre;
    end
  end

  // up to STEPS quotient bits per stage
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    dstate_t nx;
    always_comb begin
      logic [COORD_W:0] r;
      logic             qb;
      nx = stg[k-1];
      for (int i = 0; i < STEPS; i++) begin
        if ((k - 1) * STEPS + i < QB) begin
          r  = {nx.rem, nx.feed[QB-1]};
          qb = (r >= {1'b0, nx.dv});
          if (qb) begin
            r = r - {1'b0, nx.dv};
          end
          nx.rem  = r[COORD_W-1:0];
          nx.feed = {nx.feed[QB-2:0], 1'b0};
          nx.quo  = {nx.quo[QB-2:0], qb};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg[k] <= nx;
      end
    end
  end

  // saturate and apply sign
  logic [COORD_W-1:0] cap;
  logic [COORD_W-1:0] mag;
  always_comb begin
    cap = stg[NSTG].neg ? COORD_MIN : COORD_MAX;
    if (stg[NSTG].ovf || (stg[NSTG].quo > {1'b0, cap})) begin
      mag = cap;
    end else begin
      mag = stg[NSTG].quo[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[DS-1]) begin
      slab_d <= stg[NSTG].neg ? coord_t'(-mag) : coord_t'(mag);
    end
  end

endmodule

[design/rbs_checker.sv]
// Port-level checker for the slab test core, bound to the top level.
`timescale 1ns / 1ps
module rbs_checker
  import rbs_pkg::*;
  (
    input logic clk,
    input logic rst,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
  );

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a free output slot means the pipe can take a ray
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // a hit always reports a non-negative distance
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> !out_data.hit_distance[COORD_W-1])
    else $error("hit with negative distance");

endmodule

bind ray_box_slab_intersect_core rbs_checker u_rbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
